FILE: rtl/core/jds_pkg.sv
// ----------------------------------------------------------------------------
// jds_pkg: shared types and constants of the joystick drive shaper
// Sample widths, register indexes, control word between the front end and the
// merging stage, and the response-curve table built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package jds_pkg;

    // sizes
    localparam int SAMPLE_BITS      = 16;
    localparam int CURVE_INDEX_BITS = 10;
    localparam int AGE_BITS         = 8;
    localparam int TIMEOUT_BITS     = 8;
    localparam int KIND_BITS        = 2;
    localparam int MODE_BITS        = 2;

    localparam int MAG_BITS      = SAMPLE_BITS - 1;
    localparam int PROD_BITS     = 2 * SAMPLE_BITS;
    localparam int CURVE_ENTRIES = 1 << CURVE_INDEX_BITS;
    localparam int CMP_BITS      = (AGE_BITS > TIMEOUT_BITS) ? AGE_BITS : TIMEOUT_BITS;

    // lanes, in output word order
    localparam int LANES     = 4;
    localparam int LANE_LAT  = 0;
    localparam int LANE_FWD  = 1;
    localparam int LANE_VERT = 2;
    localparam int LANE_ROT  = 3;

    // input word field order
    localparam int IN_LAT   = 0;
    localparam int IN_FWD   = 1;
    localparam int IN_TWIST = 2;
    localparam int IN_VERT  = 3;

    localparam int TDATA_BITS = ((LANES * SAMPLE_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = SAMPLE_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINEAR_SCALE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ANGULAR_SCALE  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTICAL_SCALE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERSION_MODE = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRUST_ENABLE  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT_TICKS  = 3'd5;

    localparam logic [SAMPLE_BITS-1:0]  SCALE_RESET   = SAMPLE_BITS'(1) << (SAMPLE_BITS - 2);
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(1);
    localparam logic [AGE_BITS-1:0]     AGE_MAX       = '1;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_STICK    = 2'd0,
        KIND_THROTTLE = 2'd1,
        KIND_TICK     = 2'd2
    } t_kind;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_FRONT = 2'd0,
        MODE_RIGHT = 2'd1,
        MODE_BACK  = 2'd2,
        MODE_LEFT  = 2'd3
    } t_inv_mode;

    // what the merging stage does with one held axis
    typedef enum logic [1:0] {
        HOLD_KEEP = 2'd0,
        HOLD_LOAD = 2'd1,
        HOLD_ZERO = 2'd2
    } t_hold_op;

    // control word travelling alongside the lanes
    typedef struct packed {
        t_hold_op op_lat;
        t_hold_op op_fwd;
        t_hold_op op_vert;
        t_hold_op op_rot;
        logic     failsafe;
        logic     fs_vert_zero;
    } t_ctrl;

    // response curve: largest y with y^5 * 2^(7C) <= i^7 * 2^(5(S-1))
    localparam int BIG_BITS = 7 * CURVE_INDEX_BITS + 5 * MAG_BITS + 1;

    typedef logic [MAG_BITS-1:0] t_curve_rom [CURVE_ENTRIES];

    function automatic t_curve_rom build_curve_rom();
        t_curve_rom            rom;
        logic [BIG_BITS-1:0]   rhs;
        logic [BIG_BITS-1:0]   lhs;
        logic [MAG_BITS-1:0]   y;
        logic [MAG_BITS-1:0]   cand;
        int                    i;
        int                    b;
        int                    k;
        for (i = 0; i < CURVE_ENTRIES; i++) begin
            rhs = BIG_BITS'(1);
            for (k = 0; k < 7; k++) begin
                rhs = rhs * BIG_BITS'(i);
            end
            rhs = rhs << (5 * MAG_BITS);
            y = '0;
            // bitwise search from the top, the bound is monotone in y
            for (b = MAG_BITS - 1; b >= 0; b--) begin
                cand = y | (MAG_BITS'(1) << b);
                lhs  = BIG_BITS'(1);
                for (k = 0; k < 5; k++) begin
                    lhs = lhs * BIG_BITS'(cand);
                end
                lhs = lhs << (7 * CURVE_INDEX_BITS);
                if (lhs <= rhs) begin
                    y = cand;
                end
            end
            rom[i] = y;
        end
        return rom;
    endfunction

    localparam t_curve_rom CURVE_ROM = build_curve_rom();

endpackage

`default_nettype wire

FILE: rtl/core/jds_lane.sv
// ----------------------------------------------------------------------------
// jds_lane: one axis shaping lane
// Stage A: magnitude times sensitivity. Stage B: saturate, take the curve
// index and read the response-curve table. Output applies the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module jds_lane (
    input  wire                              i_clk,
    input  wire                              i_en_a,
    input  wire                              i_en_b,
    input  wire  [jds_pkg::SAMPLE_BITS-1:0]  i_raw,
    input  wire  [jds_pkg::SAMPLE_BITS-1:0]  i_scale,
    input  wire                              i_flip,
    output logic [jds_pkg::SAMPLE_BITS-1:0]  o_value
);
    import jds_pkg::*;

    logic                        neg;
    logic [SAMPLE_BITS-1:0]      mag;
    logic [PROD_BITS-1:0]        r_prod;
    logic                        r_sign_a;
    logic [SAMPLE_BITS:0]        scaled;
    logic [MAG_BITS-1:0]         mag_sat;
    logic [CURVE_INDEX_BITS-1:0] curve_idx;
    logic [MAG_BITS-1:0]         r_curve;
    logic                        r_sign_b;

    // absolute value; the most negative sample gives 2^(S-1)
    assign neg = i_raw[SAMPLE_BITS-1];
    assign mag = neg ? SAMPLE_BITS'(~i_raw + SAMPLE_BITS'(1)) : i_raw;

    // stage A: scale
    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_prod   <= PROD_BITS'(mag) * PROD_BITS'(i_scale);
            r_sign_a <= neg ^ i_flip;
        end
    end

    // back to Q1.x, saturate to full scale
    assign scaled  = r_prod[PROD_BITS-1:MAG_BITS];
    assign mag_sat = (scaled[SAMPLE_BITS] | scaled[SAMPLE_BITS-1]) ? '1 : scaled[MAG_BITS-1:0];

    generate
        if (MAG_BITS >= CURVE_INDEX_BITS) begin : g_idx_shr
            assign curve_idx = mag_sat[MAG_BITS-1 -: CURVE_INDEX_BITS];
        end else begin : g_idx_shl
            assign curve_idx = {mag_sat, {(CURVE_INDEX_BITS - MAG_BITS){1'b0}}};
        end
    endgenerate

    // stage B: registered table read
    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_curve  <= CURVE_ROM[curve_idx];
            r_sign_b <= r_sign_a;
        end
    end

    assign o_value = r_sign_b ? SAMPLE_BITS'(SAMPLE_BITS'(0) - {1'b0, r_curve})
                              : {1'b0, r_curve};

endmodule

`default_nettype wire

FILE: rtl/core/jds_merge.sv
// ----------------------------------------------------------------------------
// jds_merge: merging stage and output register
// Folds the four lane results into the held axis commands and builds the
// outgoing word, the failsafe word included.
// ----------------------------------------------------------------------------
`default_nettype none

module jds_merge (
    input  wire                                         i_clk,
    input  wire                                         i_rst_n,
    input  wire                                         i_valid,
    input  wire  jds_pkg::t_ctrl                        i_ctrl,
    input  wire  [jds_pkg::LANES-1:0][jds_pkg::SAMPLE_BITS-1:0] i_lanes,
    output logic                                        o_ready,
    output logic                                        o_m_tvalid,
    input  wire                                         i_m_tready,
    // lateral, forward, vertical, rotate; zero fill to whole bytes
    output logic [jds_pkg::TDATA_BITS-1:0]              o_m_tdata,
    // failsafe
    output logic                                        o_m_tuser
);
    import jds_pkg::*;

    logic [SAMPLE_BITS-1:0] r_held [LANES];
    logic [SAMPLE_BITS-1:0] n_held [LANES];
    t_hold_op               ops    [LANES];
    logic [SAMPLE_BITS-1:0] word   [LANES];
    logic [TDATA_BITS-1:0]  data;
    logic                   r_valid;
    logic [TDATA_BITS-1:0]  r_data;
    logic                   r_failsafe;

    assign ops[LANE_LAT]  = i_ctrl.op_lat;
    assign ops[LANE_FWD]  = i_ctrl.op_fwd;
    assign ops[LANE_VERT] = i_ctrl.op_vert;
    assign ops[LANE_ROT]  = i_ctrl.op_rot;

    // next held values
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            unique case (ops[k])
                HOLD_LOAD: n_held[k] = i_lanes[k];
                HOLD_ZERO: n_held[k] = '0;
                default:   n_held[k] = r_held[k];
            endcase
        end
    end

    // outgoing word
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            word[k] = n_held[k];
        end
        if (i_ctrl.failsafe) begin
            word[LANE_LAT]  = '0;
            word[LANE_FWD]  = '0;
            word[LANE_ROT]  = '0;
            word[LANE_VERT] = i_ctrl.fs_vert_zero ? '0 : r_held[LANE_VERT];
        end
        data = '0;
        for (int k = 0; k < LANES; k++) begin
            data[k*SAMPLE_BITS +: SAMPLE_BITS] = word[k];
        end
    end

    assign o_ready = !r_valid || i_m_tready;

    // control and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int k = 0; k < LANES; k++) begin
                r_held[k] <= '0;
            end
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                for (int k = 0; k < LANES; k++) begin
                    r_held[k] <= n_held[k];
                end
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data     <= data;
            r_failsafe <= i_ctrl.failsafe;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_failsafe;

endmodule

`default_nettype wire

FILE: rtl/core/joystick_drive_shaper.sv
// ----------------------------------------------------------------------------
// joystick_drive_shaper: joystick to drive command shaper, top level
// Input stream: joystick samples, throttle samples and watchdog ticks, the
// kind in tuser. Output stream: shaped lateral, forward, vertical and rotate
// commands with a failsafe flag in tuser. Configuration by a write port.
//
// Use:
//   - A joystick or throttle sample always yields one output word; a tick
//     yields a failsafe word only when the joystick has gone stale. An unused
//     kind and a fresh tick are absorbed in the accept cycle.
//   - The path has 3 register stages: scale multiply at the accept edge, curve
//     table read (registered), merge into the output register; tvalid rises
//     once the word is in the output register.
//   - Throughput is one word per cycle while the receiver takes words; the four
//     lanes and the merge stage are pipelined, each stage moving on when the one after it is free.
//   - When the receiver stalls, the output word holds and the pipeline fills
//     behind it; tready drops only once every stage holds a word.
//   - Reset (synchronous, active low) empties the pipeline, zeros the held
//     commands, marks both sources stale and loads default settings.
//   - Registers are written while the stream is idle; the user must keep to this, the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_drive_shaper (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // stick_lateral, stick_forward, stick_twist, stick_vertical
    input  wire  [jds_pkg::TDATA_BITS-1:0]       i_s_tdata,
    // kind
    input  wire  [jds_pkg::KIND_BITS-1:0]        i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    // cmd_lateral, cmd_forward, cmd_vertical, cmd_rotate
    output logic [jds_pkg::TDATA_BITS-1:0]       o_m_tdata,
    // failsafe
    output logic                                 o_m_tuser,
    input  wire                                  i_cfg_we,
    input  wire  [jds_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire  [jds_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import jds_pkg::*;

    // settings
    logic [SAMPLE_BITS-1:0]  r_linear_scale;
    logic [SAMPLE_BITS-1:0]  r_angular_scale;
    logic [SAMPLE_BITS-1:0]  r_vertical_scale;
    t_inv_mode               r_inv_mode;
    logic                    r_thrust_en;
    logic [TIMEOUT_BITS-1:0] r_timeout;

    // source state
    logic [AGE_BITS-1:0]     r_stick_age;
    logic [AGE_BITS-1:0]     r_throttle_age;
    logic                    r_vert_from_stick;
    logic [AGE_BITS-1:0]     n_stick_age;
    logic [AGE_BITS-1:0]     n_throttle_age;
    logic                    n_vert_from_stick;

    // pipeline control
    logic                    r_a_valid;
    t_ctrl                   r_a_ctrl;
    logic                    r_b_valid;
    t_ctrl                   r_b_ctrl;
    logic                    en_a;
    logic                    en_b;
    logic                    merge_ready;
    logic                    accept;
    logic                    push;
    t_ctrl                   ctrl;

    logic [AGE_BITS-1:0]     stick_inc;
    logic [AGE_BITS-1:0]     throttle_inc;
    logic                    stick_stale;
    logic                    throttle_stale;

    logic [SAMPLE_BITS-1:0]  in_axis    [LANES];
    logic [SAMPLE_BITS-1:0]  lane_raw   [LANES];
    logic [SAMPLE_BITS-1:0]  lane_scale [LANES];
    logic                    lane_flip  [LANES];
    logic [LANES-1:0][SAMPLE_BITS-1:0] lane_value;

    // stage enables, back to front
    assign en_b       = !r_b_valid || merge_ready;
    assign en_a       = !r_a_valid || en_b;
    assign o_s_tready = en_a;
    assign accept     = i_s_tvalid && en_a;

    // input word fields
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            in_axis[k] = i_s_tdata[k*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    // lane routing, inversion mode picks source and sign of the horizontal axes
    always_comb begin
        lane_raw[LANE_VERT]   = in_axis[IN_VERT];
        lane_scale[LANE_VERT] = r_vertical_scale;
        lane_flip[LANE_VERT]  = 1'b1;
        lane_raw[LANE_ROT]    = in_axis[IN_TWIST];
        lane_scale[LANE_ROT]  = r_angular_scale;
        lane_flip[LANE_ROT]   = 1'b1;
        lane_scale[LANE_LAT]  = r_linear_scale;
        lane_scale[LANE_FWD]  = r_linear_scale;
        unique case (r_inv_mode)
            MODE_RIGHT: begin
                lane_raw[LANE_LAT]  = in_axis[IN_FWD];
                lane_flip[LANE_LAT] = 1'b0;
                lane_raw[LANE_FWD]  = in_axis[IN_LAT];
                lane_flip[LANE_FWD] = 1'b1;
            end
            MODE_BACK: begin
                lane_raw[LANE_LAT]  = in_axis[IN_LAT];
                lane_flip[LANE_LAT] = 1'b0;
                lane_raw[LANE_FWD]  = in_axis[IN_FWD];
                lane_flip[LANE_FWD] = 1'b1;
            end
            MODE_LEFT: begin
                lane_raw[LANE_LAT]  = in_axis[IN_FWD];
                lane_flip[LANE_LAT] = 1'b1;
                lane_raw[LANE_FWD]  = in_axis[IN_LAT];
                lane_flip[LANE_FWD] = 1'b0;
            end
            default: begin
                lane_raw[LANE_LAT]  = in_axis[IN_LAT];
                lane_flip[LANE_LAT] = 1'b1;
                lane_raw[LANE_FWD]  = in_axis[IN_FWD];
                lane_flip[LANE_FWD] = 1'b0;
            end
        endcase
    end

    // saturating ages and staleness
    assign stick_inc      = (r_stick_age == AGE_MAX) ? r_stick_age
                                                     : AGE_BITS'(r_stick_age + AGE_BITS'(1));
    assign throttle_inc   = (r_throttle_age == AGE_MAX) ? r_throttle_age
                                                        : AGE_BITS'(r_throttle_age + AGE_BITS'(1));
    assign stick_stale    = CMP_BITS'(stick_inc) > CMP_BITS'(r_timeout);
    assign throttle_stale = CMP_BITS'(throttle_inc) > CMP_BITS'(r_timeout);

    // word decode: source state updates and control word for the merge
    always_comb begin
        n_stick_age       = r_stick_age;
        n_throttle_age    = r_throttle_age;
        n_vert_from_stick = r_vert_from_stick;
        push              = 1'b0;
        ctrl.op_lat       = HOLD_KEEP;
        ctrl.op_fwd       = HOLD_KEEP;
        ctrl.op_vert      = HOLD_KEEP;
        ctrl.op_rot       = HOLD_KEEP;
        ctrl.failsafe     = 1'b0;
        ctrl.fs_vert_zero = r_vert_from_stick;
        unique case (i_s_tuser)
            KIND_STICK: begin
                n_stick_age = '0;
                push        = 1'b1;
                if (r_thrust_en) begin
                    ctrl.op_lat  = HOLD_LOAD;
                    ctrl.op_fwd  = HOLD_LOAD;
                    ctrl.op_rot  = HOLD_LOAD;
                    ctrl.op_vert = r_vert_from_stick ? HOLD_LOAD : HOLD_KEEP;
                end else begin
                    ctrl.op_lat  = HOLD_ZERO;
                    ctrl.op_fwd  = HOLD_ZERO;
                    ctrl.op_rot  = HOLD_ZERO;
                    ctrl.op_vert = HOLD_ZERO;
                end
            end
            KIND_THROTTLE: begin
                n_throttle_age    = '0;
                n_vert_from_stick = 1'b0;
                push              = 1'b1;
                ctrl.op_vert      = r_thrust_en ? HOLD_LOAD : HOLD_ZERO;
            end
            KIND_TICK: begin
                n_stick_age    = stick_inc;
                n_throttle_age = throttle_inc;
                if (stick_stale) begin
                    push          = 1'b1;
                    ctrl.op_lat   = HOLD_ZERO;
                    ctrl.op_fwd   = HOLD_ZERO;
                    ctrl.op_rot   = HOLD_ZERO;
                    ctrl.failsafe = 1'b1;
                end
                if (throttle_stale) begin
                    n_vert_from_stick = 1'b1;
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    // settings and source state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear_scale    <= SCALE_RESET;
            r_angular_scale   <= SCALE_RESET;
            r_vertical_scale  <= SCALE_RESET;
            r_inv_mode        <= MODE_FRONT;
            r_thrust_en       <= 1'b0;
            r_timeout         <= TIMEOUT_RESET;
            r_stick_age       <= AGE_MAX;
            r_throttle_age    <= AGE_MAX;
            r_vert_from_stick <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LINEAR_SCALE:   r_linear_scale   <= i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_ANGULAR_SCALE:  r_angular_scale  <= i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_VERTICAL_SCALE: r_vertical_scale <= i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_INVERSION_MODE: r_inv_mode       <= t_inv_mode'(i_cfg_data[MODE_BITS-1:0]);
                    CFG_THRUST_ENABLE:  r_thrust_en      <= i_cfg_data[0];
                    CFG_TIMEOUT_TICKS:  r_timeout        <= i_cfg_data[TIMEOUT_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_stick_age       <= n_stick_age;
                r_throttle_age    <= n_throttle_age;
                r_vert_from_stick <= n_vert_from_stick;
            end
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= accept && push;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // control words alongside the lanes
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_ctrl <= ctrl;
        end
        if (en_b) begin
            r_b_ctrl <= r_a_ctrl;
        end
    end

    // four shaping lanes
    generate
        for (genvar g = 0; g < LANES; g++) begin : g_lane
            jds_lane u_lane (
                .i_clk   (i_clk),
                .i_en_a  (en_a),
                .i_en_b  (en_b),
                .i_raw   (lane_raw[g]),
                .i_scale (lane_scale[g]),
                .i_flip  (lane_flip[g]),
                .o_value (lane_value[g])
            );
        end
    endgenerate

    // merge and output register
    jds_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_b_valid),
        .i_ctrl     (r_b_ctrl),
        .i_lanes    (lane_value),
        .o_ready    (merge_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

FILE: rtl/core/jds_check.sv
// ----------------------------------------------------------------------------
// jds_check: port-level checks of the joystick drive shaper
// Watches the stream ports and flags broken output words or a blocked input.
// ----------------------------------------------------------------------------
`default_nettype none

module jds_check (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 o_s_tready,
    input wire                                 o_m_tvalid,
    input wire                                 i_m_tready,
    input wire [jds_pkg::TDATA_BITS-1:0]       o_m_tdata,
    input wire                                 o_m_tuser
);
    import jds_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {MAG_BITS{1'b0}}};

    // a stalled output word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    // an empty output register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output");

    // failsafe word carries no horizontal or rotation command
    a_failsafe_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            o_m_tdata[LANE_LAT*SAMPLE_BITS +: SAMPLE_BITS] == '0 &&
            o_m_tdata[LANE_FWD*SAMPLE_BITS +: SAMPLE_BITS] == '0 &&
            o_m_tdata[LANE_ROT*SAMPLE_BITS +: SAMPLE_BITS] == '0)
        else $error("failsafe word with non-zero axis");

    // shaped commands stay within symmetric full scale
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            o_m_tdata[LANE_LAT*SAMPLE_BITS +: SAMPLE_BITS]  != MOST_NEG &&
            o_m_tdata[LANE_FWD*SAMPLE_BITS +: SAMPLE_BITS]  != MOST_NEG &&
            o_m_tdata[LANE_VERT*SAMPLE_BITS +: SAMPLE_BITS] != MOST_NEG &&
            o_m_tdata[LANE_ROT*SAMPLE_BITS +: SAMPLE_BITS]  != MOST_NEG)
        else $error("command outside full scale");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output word after reset");

endmodule

bind joystick_drive_shaper jds_check u_jds_check (.*);

`default_nettype wire

FILE: sim/joystick_drive_shaper_test.sv
// ----------------------------------------------------------------------------
// joystick_drive_shaper_test: self-checking bench for the drive shaper
// Streams joystick, throttle and tick words into the block, predicts every
// command word from a behavioural copy of the shaper kept in the bench and
// compares the output stream field by field. Runs a short directed list, then
// random phases with different register settings and idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_drive_shaper_test;

    timeunit 1ns;
    timeprecision 1ps;

    import jds_pkg::*;

    localparam int LATENCY         = 3;
    localparam int TAIL_CYCLES     = 4 * LATENCY;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int RANDOM_PHASES   = 10;
    localparam int LIMIT_NS        = 1_000_000;
    localparam int CURVE_BIG       = 7 * CURVE_INDEX_BITS + 5 * MAG_BITS + 1;

    localparam logic [KIND_BITS-1:0]      KIND_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE   = 3'd6;
    localparam logic [MAG_BITS-1:0]       MAG_MAX     = '1;
    localparam logic [SAMPLE_BITS-1:0]    MOST_NEG    = {1'b1, {MAG_BITS{1'b0}}};
    localparam logic [SAMPLE_BITS-1:0]    MOST_POS    = {1'b0, {MAG_BITS{1'b1}}};
    localparam logic [SAMPLE_BITS-1:0]    SCALE_ONE   = MOST_NEG;

    typedef logic [SAMPLE_BITS-1:0] t_axis;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        t_axis                lat;
        t_axis                fwd;
        t_axis                twist;
        t_axis                vert;
    } t_stick_word;

    typedef struct packed {
        t_axis lat;
        t_axis fwd;
        t_axis vert;
        t_axis rot;
        logic  failsafe;
    } t_drive_cmd;

    // bench-driven signals, all known from time zero
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [TDATA_BITS-1:0]     s_tdata   = '0;
    logic [KIND_BITS-1:0]      s_tuser   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [TDATA_BITS-1:0]     m_tdata;
    logic                      m_tuser;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    logic hold_go       = 1'b0;
    int   hold_left     = 0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;

    // shaper copy: curve, settings and held state
    logic [MAG_BITS-1:0]     curve_lut [CURVE_ENTRIES];
    t_axis                   lin_scale;
    t_axis                   ang_scale;
    t_axis                   vert_scale;
    t_inv_mode               inv_mode;
    logic                    thrust_on;
    logic [TIMEOUT_BITS-1:0] timeout;
    t_axis                   held_lat;
    t_axis                   held_fwd;
    t_axis                   held_vert;
    t_axis                   held_rot;
    logic                    vert_from_stick;
    logic [AGE_BITS-1:0]     stick_age;
    logic [AGE_BITS-1:0]     throttle_age;

    t_stick_word queued_inputs [$];
    t_drive_cmd  predicted_cmds [$];

    int n_words    = 0;
    int n_ticks    = 0;
    int n_throttle = 0;
    int n_cmds     = 0;
    int n_failsafe = 0;
    int n_settings = 1;
    int n_errors   = 0;

    joystick_drive_shaper i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // y^5 scaled for the curve bound test
    function automatic logic [CURVE_BIG-1:0] curve_pow(int y);
        logic [CURVE_BIG-1:0] p;
        p = CURVE_BIG'(1);
        repeat (5) p = p * CURVE_BIG'(y);
        return p << (7 * CURVE_INDEX_BITS);
    endfunction

    // response curve: real estimate, then nudged to the exact integer bound
    initial begin : build_curve
        logic [CURVE_BIG-1:0] bound;
        int                   y;
        for (int i = 0; i < CURVE_ENTRIES; i++) begin
            bound = CURVE_BIG'(1);
            repeat (7) bound = bound * CURVE_BIG'(i);
            bound = bound << (5 * MAG_BITS);
            y = $rtoi(real'(1 << MAG_BITS) * ((real'(i) / real'(CURVE_ENTRIES)) ** 1.4));
            if (y > int'(MAG_MAX)) y = int'(MAG_MAX);
            while (y < int'(MAG_MAX) && curve_pow(y + 1) <= bound) y++;
            while (y > 0 && curve_pow(y) > bound) y--;
            curve_lut[i] = MAG_BITS'(y);
        end
    end

    // scale, saturate, look up the curve and apply the sign
    function automatic t_axis shape_axis(t_axis raw, t_axis scale, logic negate);
        logic                   neg;
        logic [SAMPLE_BITS:0]   mag;
        logic [2*SAMPLE_BITS:0] prod;
        logic [MAG_BITS-1:0]    lvl;
        t_axis                  y;
        neg  = raw[SAMPLE_BITS-1];
        mag  = neg ? -{raw[SAMPLE_BITS-1], raw} : {1'b0, raw};
        prod = mag * scale;
        if ((prod >> MAG_BITS) > MAG_MAX) begin
            lvl = MAG_MAX;
        end else begin
            lvl = prod[MAG_BITS +: MAG_BITS];
        end
        y = {1'b0, curve_lut[lvl[MAG_BITS-1 -: CURVE_INDEX_BITS]]};
        if (neg != negate) y = -y;
        return y;
    endfunction

    // one accepted word through the shaper copy; returns 1 when a command is due
    function automatic logic advance_shaper(input t_stick_word w, output t_drive_cmd cmd);
        logic emit;
        emit = 1'b1;
        cmd  = '0;
        case (w.kind)
            KIND_STICK: begin
                stick_age = '0;
                if (thrust_on) begin
                    held_rot = shape_axis(w.twist, ang_scale, 1'b1);
                    case (inv_mode)
                        MODE_RIGHT: begin
                            held_fwd = shape_axis(w.lat, lin_scale, 1'b1);
                            held_lat = shape_axis(w.fwd, lin_scale, 1'b0);
                        end
                        MODE_BACK: begin
                            held_lat = shape_axis(w.lat, lin_scale, 1'b0);
                            held_fwd = shape_axis(w.fwd, lin_scale, 1'b1);
                        end
                        MODE_LEFT: begin
                            held_fwd = shape_axis(w.lat, lin_scale, 1'b0);
                            held_lat = shape_axis(w.fwd, lin_scale, 1'b1);
                        end
                        default: begin
                            held_lat = shape_axis(w.lat, lin_scale, 1'b1);
                            held_fwd = shape_axis(w.fwd, lin_scale, 1'b0);
                        end
                    endcase
                    if (vert_from_stick) held_vert = shape_axis(w.vert, vert_scale, 1'b1);
                end else begin
                    held_lat  = '0;
                    held_fwd  = '0;
                    held_vert = '0;
                    held_rot  = '0;
                end
            end
            KIND_THROTTLE: begin
                throttle_age    = '0;
                vert_from_stick = 1'b0;
                held_vert       = thrust_on ? shape_axis(w.vert, vert_scale, 1'b1) : '0;
            end
            KIND_TICK: begin
                if (stick_age != AGE_MAX) stick_age = stick_age + 1'b1;
                if (throttle_age != AGE_MAX) throttle_age = throttle_age + 1'b1;
                emit = stick_age > timeout;
                // stale joystick: failsafe word, vertical kept only under throttle
                if (emit) begin
                    held_lat     = '0;
                    held_fwd     = '0;
                    held_rot     = '0;
                    cmd.failsafe = 1'b1;
                    cmd.vert     = vert_from_stick ? '0 : held_vert;
                end
                if (throttle_age > timeout) vert_from_stick = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        if (emit && !cmd.failsafe) begin
            cmd.lat  = held_lat;
            cmd.fwd  = held_fwd;
            cmd.vert = held_vert;
            cmd.rot  = held_rot;
        end
        return emit;
    endfunction

    function automatic void check_field(string name, t_axis want, t_axis got);
        if (want !== got) begin
            n_errors++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endfunction

    function automatic void push_word(logic [KIND_BITS-1:0] kind, t_axis lat, t_axis fwd,
                                      t_axis twist, t_axis vert);
        t_stick_word w;
        w.kind  = kind;
        w.lat   = lat;
        w.fwd   = fwd;
        w.twist = twist;
        w.vert  = vert;
        queued_inputs.push_back(w);
    endfunction

    // axis value biased towards the corners of the range
    function automatic t_axis rand_axis();
        case ($urandom_range(0, 7))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return MOST_NEG + 1'b1;
            3:       return '0;
            4:       return t_axis'($urandom_range(0, 64));
            5:       return -t_axis'($urandom_range(1, 64));
            default: return t_axis'($urandom);
        endcase
    endfunction

    // stimulus driver: offers the head of queued_inputs, with random gaps
    always @(posedge clk) begin : driver
        t_drive_cmd            cmd;
        logic                  offer;
        logic [TDATA_BITS-1:0] word;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                if (advance_shaper(queued_inputs[0], cmd)) predicted_cmds.push_back(cmd);
                n_words++;
                if (queued_inputs[0].kind == KIND_TICK) n_ticks++;
                if (queued_inputs[0].kind == KIND_THROTTLE) n_throttle++;
                void'(queued_inputs.pop_front());
                offer = 1'b0;
            end
            if (!offer && queued_inputs.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                word = '0;
                word[IN_LAT*SAMPLE_BITS   +: SAMPLE_BITS] = queued_inputs[0].lat;
                word[IN_FWD*SAMPLE_BITS   +: SAMPLE_BITS] = queued_inputs[0].fwd;
                word[IN_TWIST*SAMPLE_BITS +: SAMPLE_BITS] = queued_inputs[0].twist;
                word[IN_VERT*SAMPLE_BITS  +: SAMPLE_BITS] = queued_inputs[0].vert;
                s_tdata <= word;
                s_tuser <= queued_inputs[0].kind;
                offer = 1'b1;
            end
            s_tvalid <= offer;
        end
    end

    // long receiver hold-off, counted down here
    always @(posedge clk) begin
        if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // output monitor: checks each command word against the oldest prediction
    always @(posedge clk) begin : monitor
        t_drive_cmd want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_cmds++;
                if (m_tuser) n_failsafe++;
                if (predicted_cmds.size() == 0) begin
                    n_errors++;
                    $error("command word %h with none expected", m_tdata);
                end else begin
                    want = predicted_cmds.pop_front();
                    check_field("cmd_lateral",  want.lat,  m_tdata[LANE_LAT*SAMPLE_BITS  +: SAMPLE_BITS]);
                    check_field("cmd_forward",  want.fwd,  m_tdata[LANE_FWD*SAMPLE_BITS  +: SAMPLE_BITS]);
                    check_field("cmd_vertical", want.vert, m_tdata[LANE_VERT*SAMPLE_BITS +: SAMPLE_BITS]);
                    check_field("cmd_rotate",   want.rot,  m_tdata[LANE_ROT*SAMPLE_BITS  +: SAMPLE_BITS]);
                    check_field("failsafe",     t_axis'(want.failsafe), t_axis'(m_tuser));
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, t_axis val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    // full register set; narrow registers carry junk above their width
    task automatic write_config(t_axis lin, t_axis ang, t_axis vsc, t_inv_mode mode,
                                logic thrust, logic [TIMEOUT_BITS-1:0] tmo);
        write_reg(CFG_LINEAR_SCALE,   lin);
        write_reg(CFG_ANGULAR_SCALE,  ang);
        write_reg(CFG_VERTICAL_SCALE, vsc);
        write_reg(CFG_INVERSION_MODE, (t_axis'($urandom) << MODE_BITS) | t_axis'(mode));
        write_reg(CFG_THRUST_ENABLE,  (t_axis'($urandom) << 1) | t_axis'(thrust));
        write_reg(CFG_TIMEOUT_TICKS,  (t_axis'($urandom) << TIMEOUT_BITS) | t_axis'(tmo));
        // unused index, must leave every register alone
        write_reg(CFG_SPARE | CFG_INDEX_BITS'($urandom_range(0, 1)), t_axis'($urandom));
        @(posedge clk);
        cfg_we     <= 1'b0;
        lin_scale  = lin;
        ang_scale  = ang;
        vert_scale = vsc;
        inv_mode   = mode;
        thrust_on  = thrust;
        timeout    = tmo;
        n_settings++;
    endtask

    task automatic wait_drained();
        while (queued_inputs.size() != 0 || s_tvalid || predicted_cmds.size() != 0) begin
            @(posedge clk);
        end
        // a trailing tick or unused word may still be in flight
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // random traffic: mostly joystick samples, tick bursts around the timeout
    task automatic queue_traffic(int budget);
        int placed;
        int burst;
        int r;
        placed = 0;
        while (placed < budget) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                push_word(KIND_STICK, rand_axis(), rand_axis(), rand_axis(), rand_axis());
                placed++;
            end else if (r < 68) begin
                push_word(KIND_THROTTLE, t_axis'($urandom), t_axis'($urandom),
                          t_axis'($urandom), rand_axis());
                placed++;
            end else if (r < 95) begin
                if (timeout < 24) begin
                    burst = $urandom_range(1, int'(timeout) + 3);
                end else if ($urandom_range(0, 7) == 0) begin
                    burst = int'(timeout) + 2;
                end else begin
                    burst = $urandom_range(1, 6);
                end
                repeat (burst) begin
                    push_word(KIND_TICK, t_axis'($urandom), t_axis'($urandom),
                              t_axis'($urandom), t_axis'($urandom));
                end
                placed += burst;
            end else begin
                push_word(KIND_UNUSED, t_axis'($urandom), t_axis'($urandom),
                          t_axis'($urandom), t_axis'($urandom));
            end
        end
    endtask

    // run sequence
    initial begin : sequencer
        lin_scale       = SCALE_RESET;
        ang_scale       = SCALE_RESET;
        vert_scale      = SCALE_RESET;
        inv_mode        = MODE_FRONT;
        thrust_on       = 1'b0;
        timeout         = TIMEOUT_RESET;
        held_lat        = '0;
        held_fwd        = '0;
        held_vert       = '0;
        held_rot        = '0;
        vert_from_stick = 1'b1;
        stick_age       = AGE_MAX;
        throttle_age    = AGE_MAX;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: stale joystick failsafe, thrust off forces zeros
        push_word(KIND_TICK, '0, '0, '0, '0);
        push_word(KIND_STICK, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);
        push_word(KIND_THROTTLE, '0, '0, '0, MOST_NEG);
        push_word(KIND_UNUSED, '1, '1, '1, '1);
        wait_drained();

        // full-scale sensitivity, axis extremes and curve index steps
        write_config(SCALE_ONE, SCALE_ONE, SCALE_ONE, MODE_FRONT, 1'b1, TIMEOUT_RESET);
        push_word(KIND_STICK, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
        push_word(KIND_STICK, MOST_POS, MOST_POS, MOST_POS, MOST_POS);
        push_word(KIND_STICK, MOST_NEG + 1'b1, MOST_NEG + 1'b1, MOST_NEG + 1'b1, MOST_NEG + 1'b1);
        push_word(KIND_STICK, '0, '0, '0, '0);
        push_word(KIND_STICK, t_axis'(1), -t_axis'(1), t_axis'(32), -t_axis'(32));
        // throttle takes vertical, then the joystick goes stale with it held
        push_word(KIND_THROTTLE, '0, '0, '0, MOST_NEG);
        push_word(KIND_STICK, t_axis'(12345), -t_axis'(4321), t_axis'(777), MOST_POS);
        push_word(KIND_TICK, '0, '0, '0, '0);
        push_word(KIND_TICK, '0, '0, '0, '0);
        push_word(KIND_TICK, '0, '0, '0, '0);
        push_word(KIND_UNUSED, '0, '0, '0, '0);
        push_word(KIND_STICK, MOST_POS, MOST_NEG, t_axis'(1000), -t_axis'(1000));
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 55; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            case (p)
                0: write_config(SCALE_RESET, SCALE_RESET, SCALE_RESET, MODE_FRONT, 1'b1,
                                TIMEOUT_BITS'(3));
                1: write_config('0, '0, '0, MODE_RIGHT, 1'b1, '0);
                2: write_config('1, '1, '1, MODE_BACK, 1'b1, TIMEOUT_BITS'(254));
                3: write_config(SCALE_ONE, t_axis'($urandom_range(0, 32768)),
                                t_axis'($urandom_range(0, 32768)), MODE_LEFT, 1'b1, '1);
                4: write_config(t_axis'($urandom_range(0, 32768)),
                                t_axis'($urandom_range(0, 32768)),
                                t_axis'($urandom_range(0, 32768)),
                                t_inv_mode'($urandom_range(0, 3)), 1'b0,
                                TIMEOUT_BITS'($urandom_range(0, 6)));
                default: write_config(t_axis'($urandom_range(0, 32768)),
                                      t_axis'($urandom_range(0, 32768)),
                                      t_axis'($urandom_range(0, 32768)),
                                      t_inv_mode'($urandom_range(0, 3)),
                                      $urandom_range(0, 7) != 0,
                                      ($urandom_range(0, 3) == 0) ?
                                          TIMEOUT_BITS'($urandom_range(0, 255)) :
                                          TIMEOUT_BITS'($urandom_range(0, 8)));
            endcase
            // receiver holds off while the sender keeps offering
            if (p == 0) begin
                @(posedge clk);
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            queue_traffic(ITEMS_PER_PHASE);
            wait_drained();
        end

        $display("Run covered %0d input words (%0d throttle, %0d ticks) over %0d settings.",
                 n_words, n_throttle, n_ticks, n_settings);
        $display("%0d command words checked, %0d of them failsafe, %0d mismatches.",
                 n_cmds, n_failsafe, n_errors);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin : run_limit
        #LIMIT_NS;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/jds_pkg.sv
rtl/core/jds_lane.sv
rtl/core/jds_merge.sv
rtl/core/joystick_drive_shaper.sv
rtl/core/jds_check.sv
sim/joystick_drive_shaper_test.sv
